// File: rtl/lgme_pkg.sv
`default_nettype none
package lgme_pkg;

  localparam int COORD_W_MAX = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW = 1;

  localparam logic [9:0] FALL_PROB_RESET = 10'd500;
  localparam logic [11:0] MISS_BASE = 12'd1000;

  localparam logic [0:0] CFG_FALL_PROB = 1'b0;
  localparam logic [0:0] CFG_MOORE = 1'b1;

  localparam logic [1:0] CELL_WALL = 2'd0;
  localparam logic [1:0] CELL_EMPTY = 2'd1;
  localparam logic [1:0] CELL_PARTICLE = 2'd2;
  localparam logic [1:0] CELL_TRACKED = 2'd3;

  localparam logic [1:0] OUT_DONE = 2'd0;
  localparam logic [1:0] OUT_BLOCKED = 2'd1;
  localparam logic [1:0] OUT_RETRY = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_PLACE = 2'd1,
    ACT_MOVE = 2'd2,
    ACT_READ = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_LEFT = 2'd1,
    STEP_RIGHT = 2'd2
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TARGET,
    ST_CHECK,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  typedef struct packed {
    action_t action;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [1:0] cell_code;
    logic [9:0] particle_id;
    logic [9:0] draw;
    logic [4:0] reinject_offset;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [1:0] outcome;
    logic [1:0] read_code;
  } out_item_t;

  typedef struct packed {
    action_t action;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [1:0] cell_code;
    logic [9:0] particle_id;
    logic in_grid;
    logic id_ok;
    logic fall;
    step_t step;
    logic [COORD_W_MAX-1:0] reinj_x;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/lgme_front.sv
`default_nettype none
module lgme_front
  import lgme_pkg::*;
#(
  parameter int GRID_SIDE = 64,
  parameter int MAX_PARTICLES = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [9:0] cfg_data,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_entry
);

  localparam int HALF = GRID_SIDE / 2;
  localparam int QUARTER = GRID_SIDE / 4;

  logic [9:0] fall_prob;
  logic       moore;
  logic [COORD_W_MAX-1:0] reinj_tab [32];
  logic [11:0] d2;
  logic [11:0] d3;
  logic [11:0] p1;
  logic [11:0] p2;
  logic        fall;
  step_t       step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fall_prob <= FALL_PROB_RESET;
      moore <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FALL_PROB: fall_prob <= cfg_data;
        CFG_MOORE: moore <= cfg_data[0];
      endcase
    end
  end

  for (genvar i = 0; i < 32; i++) begin : g_reinj
    assign reinj_tab[i] = COORD_W_MAX'(i % HALF + QUARTER);
  end

  assign d2 = {1'b0, in_data.draw, 1'b0};
  assign d3 = d2 + 12'(in_data.draw);
  assign p1 = 12'(fall_prob);
  assign p2 = {1'b0, fall_prob, 1'b0};
  assign fall = in_data.draw < fall_prob;

  always_comb begin
    step = STEP_NONE;
    if (fall) begin
      if (moore && !(d3 < p1)) begin
        step = (d3 < p2) ? STEP_LEFT : STEP_RIGHT;
      end
    end else begin
      step = (d2 < MISS_BASE + p1) ? STEP_LEFT : STEP_RIGHT;
    end
  end

  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;

  always_comb begin
    q_entry.action = in_data.action;
    q_entry.cell_x = in_data.cell_x;
    q_entry.cell_y = in_data.cell_y;
    q_entry.cell_code = in_data.cell_code;
    q_entry.particle_id = in_data.particle_id;
    q_entry.in_grid = (9'(in_data.cell_x) < 9'(GRID_SIDE)) &&
                      (9'(in_data.cell_y) < 9'(GRID_SIDE));
    q_entry.id_ok = 13'(in_data.particle_id) < 13'(MAX_PARTICLES);
    q_entry.fall = fall;
    q_entry.step = step;
    q_entry.reinj_x = reinj_tab[in_data.reinject_offset];
  end

endmodule
`default_nettype wire

// File: rtl/lgme_queue.sv
`default_nettype none
module lgme_queue
  import lgme_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t entry,
  output logic      full,
  output logic      empty,
  input  wire logic pop,
  output cmd_t      head
);

  cmd_t slots [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr;
  logic [QUEUE_PW-1:0] rd_ptr;
  logic [QUEUE_PW:0]   count;

  assign full = count == (QUEUE_PW + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/lgme_back.sv
`default_nettype none
module lgme_back
  import lgme_pkg::*;
#(
  parameter int GRID_SIDE = 64,
  parameter int MAX_PARTICLES = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire cmd_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  localparam int CW = $clog2(GRID_SIDE);
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW = $clog2(CELLS);
  localparam int PIW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam logic [CW-1:0] TOP = CW'(GRID_SIDE - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y);
    return AW'(AW'(x) * AW'(GRID_SIDE)) + AW'(y);
  endfunction

  logic [1:0]      grid [CELLS];
  logic [2*CW-1:0] ptab [MAX_PARTICLES];

  state_t state;
  state_t state_next;
  cmd_t   cmd;
  logic [CW-1:0] px;
  logic [CW-1:0] py;
  logic [CW-1:0] tx;
  logic [CW-1:0] ty;
  logic          reinj;
  out_item_t     res;
  out_item_t     res_next;
  logic [1:0]      g_rdata;
  logic [2*CW-1:0] p_rdata;
  logic            out_load;

  logic            g_we;
  logic [AW-1:0]   g_waddr;
  logic [1:0]      g_wdata;
  logic [AW-1:0]   g_raddr;
  logic            p_we;
  logic [2*CW-1:0] p_wdata;

  logic [CW-1:0]  cur_x;
  logic [CW-1:0]  cur_y;
  logic [PIW-1:0] cur_id;
  logic [AW-1:0]  cur_addr;
  logic [1:0]     new_code;
  logic [CW-1:0]  old_x;
  logic [CW-1:0]  old_y;
  logic [CW-1:0]  t_tx;
  logic [CW-1:0]  t_ty;
  logic           t_edge;
  logic           t_reinj;

  assign cur_x = CW'(cmd.cell_x);
  assign cur_y = CW'(cmd.cell_y);
  assign cur_id = PIW'(cmd.particle_id);
  assign cur_addr = cell_addr(cur_x, cur_y);
  assign new_code = (cmd.particle_id == '0) ? CELL_TRACKED : CELL_PARTICLE;
  assign old_x = p_rdata[2*CW-1:CW];
  assign old_y = p_rdata[CW-1:0];

  always_ff @(posedge clk) begin
    if (g_we) begin
      grid[g_waddr] <= g_wdata;
    end
    g_rdata <= grid[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      ptab[cur_id] <= p_wdata;
    end
    p_rdata <= ptab[cur_id];
  end

  always_comb begin
    t_reinj = cmd.fall && (old_y == '0);
    t_edge = 1'b0;
    t_tx = old_x;
    t_ty = old_y;
    if (t_reinj) begin
      t_tx = CW'(cmd.reinj_x);
      t_ty = TOP;
    end else begin
      if (cmd.fall) begin
        t_ty = old_y - CW'(1);
      end
      unique case (cmd.step)
        STEP_LEFT: begin
          t_edge = old_x == '0;
          t_tx = old_x - CW'(1);
        end
        STEP_RIGHT: begin
          t_edge = old_x == TOP;
          t_tx = old_x + CW'(1);
        end
        default: t_tx = old_x;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_head;
    end
    if (state == ST_TARGET) begin
      px <= old_x;
      py <= old_y;
      tx <= t_tx;
      ty <= t_ty;
      reinj <= t_reinj;
    end
    res <= res_next;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    out_load = 1'b0;
    g_we = 1'b0;
    g_waddr = cur_addr;
    g_wdata = new_code;
    g_raddr = cur_addr;
    p_we = 1'b0;
    p_wdata = {cur_x, cur_y};
    res_next = res;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        res_next.pos_x = cmd.cell_x;
        res_next.pos_y = cmd.cell_y;
        res_next.outcome = OUT_DONE;
        res_next.read_code = CELL_WALL;
        state_next = ST_RESULT;
        priority if ((cmd.action == ACT_LOAD || cmd.action == ACT_READ) &&
                     !cmd.in_grid) begin
          res_next.outcome = OUT_BLOCKED;
        end else if ((cmd.action == ACT_PLACE || cmd.action == ACT_MOVE) &&
                     !cmd.id_ok) begin
          res_next.pos_x = '0;
          res_next.pos_y = '0;
          res_next.outcome = OUT_BLOCKED;
        end else if (cmd.action == ACT_PLACE && !cmd.in_grid) begin
          res_next.outcome = OUT_BLOCKED;
        end else begin
          unique case (cmd.action)
            ACT_LOAD: begin
              g_we = 1'b1;
              g_wdata = cmd.cell_code;
            end
            ACT_READ: state_next = ST_CHECK;
            ACT_PLACE: state_next = ST_CHECK;
            ACT_MOVE: state_next = ST_TARGET;
          endcase
        end
      end
      ST_TARGET: begin
        g_raddr = cell_addr(t_tx, t_ty);
        if (!t_reinj && t_edge) begin
          res_next.pos_x = 6'(old_x);
          res_next.pos_y = 6'(old_y);
          res_next.outcome = OUT_BLOCKED;
          state_next = ST_RESULT;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = ST_RESULT;
        unique case (cmd.action)
          ACT_READ: res_next.read_code = g_rdata;
          ACT_PLACE: begin
            if (g_rdata == CELL_EMPTY) begin
              g_we = 1'b1;
              p_we = 1'b1;
            end else begin
              res_next.outcome = OUT_RETRY;
            end
          end
          ACT_MOVE: begin
            if (g_rdata == CELL_EMPTY) begin
              g_we = 1'b1;
              g_waddr = cell_addr(tx, ty);
              p_we = 1'b1;
              p_wdata = {tx, ty};
              res_next.pos_x = 6'(tx);
              res_next.pos_y = 6'(ty);
              state_next = ST_CLEAR;
            end else begin
              res_next.pos_x = 6'(px);
              res_next.pos_y = 6'(py);
              res_next.outcome = reinj ? OUT_RETRY : OUT_BLOCKED;
            end
          end
          ACT_LOAD: state_next = ST_RESULT;
        endcase
      end
      ST_CLEAR: begin
        g_we = 1'b1;
        g_waddr = cell_addr(px, py);
        g_wdata = CELL_EMPTY;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

// File: rtl/lattice_granular_move_engine.sv
// Granular lattice move engine: a grid of 2-bit cells plus a particle position table.
// Input channel: in_valid / in_stall carry one action beat (load cell, place particle,
// move particle, read cell). The beat is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall carry exactly one result beat per action,
// in order: the particle position (or echoed cell), the outcome and the read code.
// Config channel: cfg_valid / cfg_ready write fall_prob_milli (index 0) or
// moore_mode (index 1); cfg_ready is always high. Write config only while idle.
// A front stage classifies each beat and pushes it into a two-entry queue; a back
// sequencer pops it and works it against a grid memory with one read and one write
// port and a single-port position memory, one action at a time. A load or an action
// refused at decode goes DECODE then RESULT; read and place go DECODE, CHECK, RESULT;
// a move goes DECODE, TARGET, CHECK, CLEAR, RESULT (particle read, target read, two
// grid writes on the one write port), ending early if the move is blocked.
// Reset clears the queue, the sequencer and out_valid and restores the config
// registers; grid and position memories are left as they are until written.
// While out_stall is high the result beat holds, the sequencer waits with the next
// result, and once the queue is full in_stall rises.
`default_nettype none
module lattice_granular_move_engine
  import lgme_pkg::*;
#(
  parameter int GRID_SIDE = 64,
  parameter int MAX_PARTICLES = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [9:0] cfg_data
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_entry;
  cmd_t q_head;

  lgme_front #(
    .GRID_SIDE(GRID_SIDE),
    .MAX_PARTICLES(MAX_PARTICLES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_full(q_full),
    .q_push(q_push),
    .q_entry(q_entry)
  );

  lgme_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .entry(q_entry),
    .full(q_full),
    .empty(q_empty),
    .pop(q_pop),
    .head(q_head)
  );

  lgme_back #(
    .GRID_SIDE(GRID_SIDE),
    .MAX_PARTICLES(MAX_PARTICLES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_head(q_head),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
`default_nettype wire
